/* src/ppm_pc_pkg.sv */
`default_nettype none
package ppm_pc_pkg;

  localparam int WINDOW_SAMPLES = 16;
  localparam int FILL_W         = $clog2(WINDOW_SAMPLES + 1);
  // Offsets away from every pulse center: ones are penalized, zeros are noise
  localparam logic [WINDOW_SAMPLES-1:0] GAP_MASK = 16'b0000_0100_0001_0000;
  localparam int MIN_HITS       = 4;
  localparam int GAIN_SHIFT     = 8;
  // Magnitude of (noise - average) * numerator fits in this many bits
  localparam int DIV_W          = 23;
  localparam int CNT_W          = $clog2(DIV_W);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_THRESHOLD      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_GAIN          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNEXPECTED_PENALTY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_NUMERATOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_DENOMINATOR = 3'd5;

  localparam logic signed [5:0] BASE_THRESHOLD_RST     = 6'sd8;
  localparam logic [7:0]        NOISE_GAIN_RST         = 8'd64;
  localparam logic [3:0]        UNEXPECTED_PENALTY_RST = 4'd2;
  localparam logic [15:0]       DEAD_TIME_RST          = 16'd240;
  localparam logic [7:0]        AVERAGE_NUMERATOR_RST  = 8'd1;
  localparam logic [7:0]        AVERAGE_DENOM_RST      = 8'd8;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCORE  = 7'b0000010,
    ST_THRESH = 7'b0000100,
    ST_PREP   = 7'b0001000,
    ST_DIV    = 7'b0010000,
    ST_UPDATE = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

endpackage
`default_nettype wire

/* src/ppm_preamble_correlator.sv */
`default_nettype none
// An accepted sample runs through ST_SCORE, then ST_DONE for a window that is not
// scored; a scored window goes on to ST_THRESH, and a miss then through ST_PREP,
// the 23-step restoring divider of the noise average update (ST_DIV) and ST_UPDATE.
// No new sample is taken until the result is loaded into the output register.
// Reset (rst_n low at a clock edge) clears the window, counters, noise
// average, pending result and loads the configuration defaults.
module ppm_preamble_correlator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Sample input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [0] sample_bit, [7:1] zero
  // Result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [0] detected, [32:1] start_position,
                                       // [38:33] match_score, [39] zero
  // Configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [ppm_pc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ppm_pc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int WS = ppm_pc_pkg::WINDOW_SAMPLES;
  localparam int DW = ppm_pc_pkg::DIV_W;

  // Configuration registers
  logic signed [5:0] base_level_r;
  logic [7:0]        gain_r;
  logic [3:0]        penalty_r;
  logic [15:0]       dead_r;
  logic [7:0]        num_r;
  logic [7:0]        den_r;

  // Channel state
  ppm_pc_pkg::state_t state_r, state_nxt;
  logic [WS-1:0]                  win_r;
  logic [ppm_pc_pkg::FILL_W-1:0]  fill_r;
  logic [31:0]                    idx_r;
  logic [31:0]                    start_r;
  logic [31:0]                    last_det_r;
  logic signed [15:0]             avg_r;

  // Evaluation working registers
  logic signed [5:0]  score_r;
  logic               hits_ok_r;
  logic [1:0]         noise_r;
  logic signed [25:0] prod_r;
  logic [DW-1:0]      quo_r;
  logic [7:0]         rem_r;
  logic               neg_r;
  logic [ppm_pc_pkg::CNT_W-1:0] cnt_r;

  // Result staging and output register
  logic               res_det_r;
  logic [31:0]        res_pos_r;
  logic signed [5:0]  res_score_r;
  logic               out_valid_r;
  logic [39:0]        out_data_r;

  logic in_xfer, out_xfer, out_load;
  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_valid_r && out_tready;
  assign out_load = (state_r == ppm_pc_pkg::ST_DONE) && (!out_valid_r || out_tready);

  assign in_tready  = (state_r == ppm_pc_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Window scoring: hits outside the gap offsets, ones and zeros in the gaps
  logic [3:0]        hits;
  logic [1:0]        gap_ones;
  logic [4:0]        pen_total;
  logic signed [5:0] score_c;
  logic              skip;

  always_comb begin
    hits = '0;
    for (int k = 0; k < WS; k++) begin
      if (!ppm_pc_pkg::GAP_MASK[k]) begin
        hits = hits + 4'(win_r[k]);
      end
    end
  end

  assign gap_ones = 2'(win_r[4]) + 2'(win_r[10]);

  always_comb begin
    unique case (gap_ones)
      2'd0:    pen_total = 5'd0;
      2'd1:    pen_total = {1'b0, penalty_r};
      default: pen_total = {penalty_r, 1'b0};
    endcase
  end

  assign score_c = $signed({2'b00, hits}) - $signed({1'b0, pen_total});
  assign skip    = (fill_r < ppm_pc_pkg::FILL_W'(WS))
                   || ((start_r - last_det_r) < {16'd0, dead_r});

  // Shared multiplier: gain * average while scoring, then
  // (noise - average) * numerator for the average update
  logic [7:0]         mul_a;
  logic signed [17:0] mul_b;
  logic signed [26:0] mul_p;
  logic signed [17:0] diff;

  assign diff = $signed({16'd0, noise_r}) - $signed({{2{avg_r[15]}}, avg_r});

  always_comb begin
    if (state_r == ppm_pc_pkg::ST_SCORE) begin
      mul_a = gain_r;
      mul_b = $signed({{2{avg_r[15]}}, avg_r});
    end else begin
      mul_a = num_r;
      mul_b = diff;
    end
  end

  assign mul_p = $signed({1'b0, mul_a}) * mul_b;

  // Threshold: base + product / 256, rounded toward zero
  logic signed [25:0] prod_adj;
  logic signed [18:0] thr;
  logic               det_hit;

  assign prod_adj = prod_r + (prod_r[25] ? 26'sd255 : 26'sd0);
  assign thr      = $signed({{13{base_level_r[5]}}, base_level_r})
                    + $signed({prod_adj[25], prod_adj[25:8]});
  assign det_hit  = ($signed({{13{score_r[5]}}, score_r}) >= thr) && hits_ok_r;

  // Restoring division step, zero denominator read as one
  logic [7:0] den_eff;
  logic [8:0] rem_sh;
  logic       div_ge;

  assign den_eff = (den_r == 8'd0) ? 8'd1 : den_r;
  assign rem_sh  = {rem_r, quo_r[DW-1]};
  assign div_ge  = rem_sh >= {1'b0, den_eff};

  // Average update with saturation to 16 bits
  logic signed [24:0] quot_s;
  logic signed [24:0] avg_sum;
  logic signed [15:0] avg_sat;

  assign quot_s  = neg_r ? -$signed({2'b00, quo_r}) : $signed({2'b00, quo_r});
  assign avg_sum = $signed({{9{avg_r[15]}}, avg_r}) + quot_s;

  always_comb begin
    priority if (avg_sum > 25'sd32767) begin
      avg_sat = 16'sh7FFF;
    end else if (avg_sum < -25'sd32768) begin
      avg_sat = 16'sh8000;
    end else begin
      avg_sat = avg_sum[15:0];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppm_pc_pkg::ST_IDLE:   if (in_xfer) state_nxt = ppm_pc_pkg::ST_SCORE;
      ppm_pc_pkg::ST_SCORE:  state_nxt = skip ? ppm_pc_pkg::ST_DONE : ppm_pc_pkg::ST_THRESH;
      ppm_pc_pkg::ST_THRESH: state_nxt = det_hit ? ppm_pc_pkg::ST_DONE : ppm_pc_pkg::ST_PREP;
      ppm_pc_pkg::ST_PREP:   state_nxt = ppm_pc_pkg::ST_DIV;
      ppm_pc_pkg::ST_DIV: begin
        if (cnt_r == ppm_pc_pkg::CNT_W'(DW - 1)) state_nxt = ppm_pc_pkg::ST_UPDATE;
      end
      ppm_pc_pkg::ST_UPDATE: state_nxt = ppm_pc_pkg::ST_DONE;
      ppm_pc_pkg::ST_DONE:   if (out_load) state_nxt = ppm_pc_pkg::ST_IDLE;
      default:               state_nxt = ppm_pc_pkg::ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ppm_pc_pkg::ST_IDLE;
      win_r        <= '0;
      fill_r       <= '0;
      idx_r        <= '0;
      last_det_r   <= '0;
      avg_r        <= '0;
      out_valid_r  <= 1'b0;
      base_level_r <= ppm_pc_pkg::BASE_THRESHOLD_RST;
      gain_r       <= ppm_pc_pkg::NOISE_GAIN_RST;
      penalty_r    <= ppm_pc_pkg::UNEXPECTED_PENALTY_RST;
      dead_r       <= ppm_pc_pkg::DEAD_TIME_RST;
      num_r        <= ppm_pc_pkg::AVERAGE_NUMERATOR_RST;
      den_r        <= ppm_pc_pkg::AVERAGE_DENOM_RST;
    end else begin
      state_r <= state_nxt;

      // Configuration writes; unknown indexes are dropped
      if (cfg_we) begin
        unique case (cfg_index)
          ppm_pc_pkg::REG_BASE_THRESHOLD:      base_level_r <= $signed(cfg_wdata[5:0]);
          ppm_pc_pkg::REG_NOISE_GAIN:          gain_r       <= cfg_wdata[7:0];
          ppm_pc_pkg::REG_UNEXPECTED_PENALTY:  penalty_r    <= cfg_wdata[3:0];
          ppm_pc_pkg::REG_DEAD_TIME:           dead_r       <= cfg_wdata;
          ppm_pc_pkg::REG_AVERAGE_NUMERATOR:   num_r        <= cfg_wdata[7:0];
          ppm_pc_pkg::REG_AVERAGE_DENOMINATOR: den_r        <= cfg_wdata[7:0];
          default: ;
        endcase
      end

      // Shift the new sample in at the newest end, advance the index
      if (in_xfer) begin
        win_r <= {in_tdata[0], win_r[WS-1:1]};
        idx_r <= idx_r + 32'd1;
        if (fill_r < ppm_pc_pkg::FILL_W'(WS)) fill_r <= fill_r + ppm_pc_pkg::FILL_W'(1);
      end

      // Detection opens the dead time
      if (state_r == ppm_pc_pkg::ST_THRESH && det_hit) last_det_r <= start_r;

      if (state_r == ppm_pc_pkg::ST_UPDATE) avg_r <= avg_sat;

      // Hold the result until the transfer, reload when the sequencer finishes
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) start_r <= idx_r - 32'(WS - 1);

    unique case (state_r)
      ppm_pc_pkg::ST_SCORE: begin
        score_r   <= score_c;
        hits_ok_r <= hits >= 4'(ppm_pc_pkg::MIN_HITS);
        noise_r   <= 2'd2 - gap_ones;
        prod_r    <= mul_p[25:0];
        res_det_r   <= 1'b0;
        res_pos_r   <= skip ? 32'd0 : start_r;
        res_score_r <= skip ? 6'sd0 : score_c;
      end
      ppm_pc_pkg::ST_THRESH: begin
        res_det_r <= det_hit;
        prod_r    <= mul_p[25:0];
      end
      ppm_pc_pkg::ST_PREP: begin
        neg_r <= prod_r[25];
        quo_r <= prod_r[25] ? DW'(-prod_r) : DW'(prod_r);
        rem_r <= '0;
        cnt_r <= '0;
      end
      ppm_pc_pkg::ST_DIV: begin
        quo_r <= {quo_r[DW-2:0], div_ge};
        rem_r <= div_ge ? 8'(rem_sh - {1'b0, den_eff}) : rem_sh[7:0];
        cnt_r <= cnt_r + ppm_pc_pkg::CNT_W'(1);
      end
      default: ;
    endcase

    if (out_load) begin
      out_data_r <= {1'b0, res_score_r, res_pos_r, res_det_r};
    end
  end

  // Checks
  a_accept_starts_scoring: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == ppm_pc_pkg::ST_SCORE)
    else $error("accepted sample did not start scoring");

  a_div_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ppm_pc_pkg::ST_DIV |-> cnt_r < ppm_pc_pkg::CNT_W'(DW))
    else $error("divider ran past its last step");

  a_last_det_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == ppm_pc_pkg::ST_THRESH && det_hit) |=> $stable(last_det_r))
    else $error("last detection moved without a detection");

  a_avg_only_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ppm_pc_pkg::ST_UPDATE |=> $stable(avg_r))
    else $error("noise average moved outside its update step");

endmodule
`default_nettype wire

/* bench/ppm_preamble_correlator_test.sv */
`timescale 1ns / 100ps

module ppm_preamble_correlator_test;

  // Clean preamble: ones at the pulse centers 0, 2, 6, 8, 12, 14, zeros elsewhere
  localparam logic [ppm_pc_pkg::WINDOW_SAMPLES-1:0] PREAMBLE_TEMPLATE = 16'h5145;
  // Cycles without any transfer before the run is declared hung
  localparam int STALL_LIMIT = 5000;
  // Length of the receiver hold-off that backs the block up
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_PHASE  = 6;
  localparam int PHASE_COUNT = 8;

  typedef struct packed {
    logic        detected;
    logic [31:0] start_position;
    logic [5:0]  match_score;
  } decision_t;

  // Scores each window the way the block should and keeps the decisions
  // in arrival order until the block hands them out.
  class window_scorer;
    logic [ppm_pc_pkg::WINDOW_SAMPLES-1:0] window;
    int          fill;
    logic [31:0] next_index;
    logic [31:0] last_detection;
    int          noise_avg;
    int          base_level;
    int          gain;
    int          penalty;
    int          numer;
    int          denom;
    logic [31:0] dead_len;
    decision_t   pending_decisions[$];
    int          mismatches;

    function new();
      window         = '0;
      fill           = 0;
      next_index     = '0;
      last_detection = '0;
      noise_avg      = 0;
      base_level     = int'(ppm_pc_pkg::BASE_THRESHOLD_RST);
      gain           = int'(ppm_pc_pkg::NOISE_GAIN_RST);
      penalty        = int'(ppm_pc_pkg::UNEXPECTED_PENALTY_RST);
      dead_len       = {16'd0, ppm_pc_pkg::DEAD_TIME_RST};
      numer          = int'(ppm_pc_pkg::AVERAGE_NUMERATOR_RST);
      denom          = int'(ppm_pc_pkg::AVERAGE_DENOM_RST);
      mismatches     = 0;
    endfunction

    function void set_reg(logic [ppm_pc_pkg::CFG_IDX_W-1:0] idx,
                          logic [ppm_pc_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        ppm_pc_pkg::REG_BASE_THRESHOLD:      base_level = int'($signed(value[5:0]));
        ppm_pc_pkg::REG_NOISE_GAIN:          gain       = int'(value[7:0]);
        ppm_pc_pkg::REG_UNEXPECTED_PENALTY:  penalty    = int'(value[3:0]);
        ppm_pc_pkg::REG_DEAD_TIME:           dead_len   = {16'd0, value};
        ppm_pc_pkg::REG_AVERAGE_NUMERATOR:   numer      = int'(value[7:0]);
        ppm_pc_pkg::REG_AVERAGE_DENOMINATOR: denom      = int'(value[7:0]);
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_decisions.size();
    endfunction

    function void note_sample(logic sample);
      decision_t   d;
      logic [31:0] start;
      logic [31:0] age;
      int          hits;
      int          gap_ones;
      int          quiet;
      int          score;
      int          thr;
      int          den;
      int          nv;
      window     = {sample, window[ppm_pc_pkg::WINDOW_SAMPLES-1:1]};
      start      = next_index - 32'(ppm_pc_pkg::WINDOW_SAMPLES - 1);
      next_index = next_index + 32'd1;
      if (fill < ppm_pc_pkg::WINDOW_SAMPLES) fill++;
      age = start - last_detection;
      d   = '0;
      if (fill == ppm_pc_pkg::WINDOW_SAMPLES && age >= dead_len) begin
        hits     = 0;
        gap_ones = 0;
        quiet    = 0;
        for (int k = 0; k < ppm_pc_pkg::WINDOW_SAMPLES; k++) begin
          if (ppm_pc_pkg::GAP_MASK[k]) begin
            if (window[k]) gap_ones++;
            else quiet++;
          end else if (window[k]) begin
            hits++;
          end
        end
        score = hits - gap_ones * penalty;
        // signed int division truncates toward zero
        thr = base_level + (gain * noise_avg) / (1 << ppm_pc_pkg::GAIN_SHIFT);
        d.start_position = start;
        d.match_score    = score[5:0];
        if (score >= thr && hits >= ppm_pc_pkg::MIN_HITS) begin
          d.detected     = 1'b1;
          last_detection = start;
        end else begin
          den = (denom == 0) ? 1 : denom;
          nv  = noise_avg + ((quiet - noise_avg) * numer) / den;
          if (nv > 32767) nv = 32767;
          if (nv < -32768) nv = -32768;
          noise_avg = nv;
        end
      end
      pending_decisions.push_back(d);
    endfunction

    function void check_decision(logic [39:0] beat);
      decision_t want;
      decision_t got;
      got.detected       = beat[0];
      got.start_position = beat[32:1];
      got.match_score    = beat[38:33];
      if (pending_decisions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing pending: tdata %h", beat);
        return;
      end
      want = pending_decisions.pop_front();
      if (got.detected !== want.detected || got.start_position !== want.start_position ||
          got.match_score !== want.match_score) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: detected %b/%b start %h/%h score %0d/%0d (expected/actual)",
                   want.detected, got.detected, want.start_position, got.start_position,
                   $signed(want.match_score), $signed(got.match_score));
      end
    endfunction
  endclass

  logic                              clk        = 1'b0;
  logic                              rst_n      = 1'b0;
  logic                              in_tvalid  = 1'b0;
  logic                              in_tready;
  logic [7:0]                        in_tdata   = 8'd0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [39:0]                       out_tdata;
  logic                              cfg_we     = 1'b0;
  logic [ppm_pc_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [ppm_pc_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;

  window_scorer scorer;
  int items_sent    = 0;
  int phase_no      = -1;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  ppm_preamble_correlator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Offer one sample; call at a falling edge, return at a falling edge.
  // Keep tvalid high between back-to-back samples so it never toggles
  // within one time step.
  task automatic send_sample(input logic sample);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, sample};
    do @(posedge clk); while (!in_tready);
    // transfer happened at this edge: predict its decision now
    scorer.note_sample(sample);
    items_sent++;
    @(negedge clk);
  endtask

  // One burst of stimulus: mostly noisy preambles, some raw noise and some
  // preambles cut short.
  task automatic send_burst();
    int                                    kind;
    int                                    len;
    logic [ppm_pc_pkg::WINDOW_SAMPLES-1:0] pattern;
    kind    = $urandom_range(0, 9);
    pattern = PREAMBLE_TEMPLATE;
    for (int k = 0; k < ppm_pc_pkg::WINDOW_SAMPLES; k++) begin
      if (ppm_pc_pkg::GAP_MASK[k]) begin
        if ($urandom_range(0, 7) == 0) pattern[k] = 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        pattern[k] = ~pattern[k];
      end
    end
    if (kind <= 6) begin
      for (int k = 0; k < ppm_pc_pkg::WINDOW_SAMPLES; k++) send_sample(pattern[k]);
      len = $urandom_range(0, 8);
      repeat (len) send_sample($urandom_range(0, 5) == 0);
    end else if (kind <= 8) begin
      len = $urandom_range(1, 20);
      repeat (len) send_sample($urandom_range(0, 1) == 1);
    end else begin
      len = $urandom_range(3, 12);
      for (int k = 0; k < len; k++) send_sample(pattern[k]);
    end
  endtask

  task automatic run_items(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) send_burst();
    in_tvalid <= 1'b0;
  endtask

  // Wait until every predicted decision has come out, then let the block settle.
  task automatic drain();
    while (scorer.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [ppm_pc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ppm_pc_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    scorer.set_reg(idx, value);
    @(negedge clk);
  endtask

  // Load all six registers while the block is idle; base is taken as 6-bit two's complement.
  task automatic apply_settings(input logic [5:0] base, input logic [7:0] gain,
                                input logic [3:0] pen, input logic [15:0] dead,
                                input logic [7:0] numer, input logic [7:0] denom);
    drain();
    write_reg(ppm_pc_pkg::REG_BASE_THRESHOLD, {10'd0, base});
    write_reg(ppm_pc_pkg::REG_NOISE_GAIN, {8'd0, gain});
    write_reg(ppm_pc_pkg::REG_UNEXPECTED_PENALTY, {12'd0, pen});
    write_reg(ppm_pc_pkg::REG_DEAD_TIME, dead);
    write_reg(ppm_pc_pkg::REG_AVERAGE_NUMERATOR, {8'd0, numer});
    write_reg(ppm_pc_pkg::REG_AVERAGE_DENOMINATOR, {8'd0, denom});
    cfg_we <= 1'b0;
  endtask

  // Receiver: random backpressure, plus one long hold-off so the block fills up
  // and stalls its input while the sender keeps offering.
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_no == HOLD_PHASE && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) scorer.check_decision(out_tdata);
  end

  // Watchdog: end the run if nothing transfers for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    scorer = new();
    send_idle_pct = 17;
    recv_idle_pct = 71;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: with reset settings the window fills (no evaluation for the
    // first fifteen samples), then the first full window lies in dead time.
    for (int k = 0; k < ppm_pc_pkg::WINDOW_SAMPLES; k++) send_sample(PREAMBLE_TEMPLATE[k]);
    in_tvalid <= 1'b0;
    // Lowest threshold, no dead time, harshest penalty, zero denominator.
    apply_settings(6'h20, 8'd0, 4'd15, 16'd0, 8'd255, 8'd0);
    for (int k = 0; k < 8; k++) send_sample(PREAMBLE_TEMPLATE[k]);
    in_tvalid <= 1'b0;

    for (int p = 0; p < PHASE_COUNT; p++) begin
      // first the sender idles lightly and the receiver heavily, then swap, then none
      if (p < 3) begin
        send_idle_pct = 17;
        recv_idle_pct = 71;
      end else if (p < 6) begin
        send_idle_pct = 71;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        // highest base threshold and gain: the average swings into saturation
        0: apply_settings(6'h1F, 8'd255, 4'd15, 16'd0, 8'd255, 8'd1);
        // lowest threshold, no penalty, zero denominator
        1: apply_settings(6'h20, 8'd255, 4'd0, 16'd0, 8'd255, 8'd0);
        // longest dead time: every window after the last detection is skipped
        2: apply_settings(6'h08, 8'd64, 4'd2, 16'hFFFF, 8'd1, 8'd8);
        // frozen average, widest denominator
        5: apply_settings(6'h00, 8'd128, 4'd1, 16'd3, 8'd0, 8'd255);
        default: apply_settings(6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                                4'($urandom_range(0, 15)), 16'($urandom_range(0, 30)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      phase_no = p;
      run_items((p == 2) ? 40 : 130);
    end

    drain();
    repeat (8) @(posedge clk);
    if (scorer.mismatches == 0 && scorer.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
